// ----- design/mdio_mfm_pkg.sv -----
// Shared types and constants for the MDIO clause 22 frame master.
// Request and result structs, operation codes, frame field codes.
// No dependencies.
package mdio_mfm_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NONE  = 2'd3
	} mdio_op_t;

	typedef enum logic [1:0] {
		CFG_PHY_ADDRESS = 2'd0,
		CFG_PHASE_TICKS = 2'd1,
		CFG_SPARE2      = 2'd2,
		CFG_SPARE3      = 2'd3
	} mdio_cfg_idx_t;

	localparam logic [1:0] MDIO_ST     = 2'b01;
	localparam logic [1:0] MDIO_OP_RD  = 2'b10;
	localparam logic [1:0] MDIO_OP_WR  = 2'b01;
	localparam logic [1:0] MDIO_TA_WR  = 2'b10;
	localparam logic [1:0] MDIO_TA_RD  = 2'b00;

	typedef struct packed {
		logic [1:0]  operation;
		logic [4:0]  reg_num;
		logic [15:0] write_data;
		logic        mdio_in;
	} mdio_req_t;

	typedef struct packed {
		logic        mdc;
		logic        mdio_out;
		logic        mdio_drive;
		logic        busy_res;
		logic        done_res;
		logic [15:0] read_value;
		logic        rejected;
	} mdio_res_t;

endpackage

// ----- design/mdio_management_frame_master.sv -----
// MDIO clause 22 management frame master, top level.
// Depends on mdio_mfm_pkg for the request and result types and codes.
//
// Usage: each request on req/req_valid/req_ready is a start read, a start
// write or a tick. A start latches the frame header (with the configured PHY
// address) and shows the pin levels of the first phase; each tick then
// advances the MDC/MDIO sequence by one tick of a quarter-bit phase. Every
// request gives exactly one result on res/res_valid/res_ready with the pin
// levels, busy, done, the read value on the done tick and a reject flag for a
// start that arrived while a frame was running.
// The result is registered, shown in the cycle after its request is taken; one
// request is taken every cycle, set by the single state update between state
// registers and the result register. When the receiver stalls, the result
// register holds; a new request is taken only when the held result is taken.
// Configuration writes on cfg_valid/cfg_ready/cfg_index/cfg_data are always
// taken; index 0 is the PHY address, index 1 the ticks per phase.
// Reset leaves the block idle, MDC low, MDIO released, phase_ticks at 2.
module mdio_management_frame_master #(
	parameter int PREAMBLE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  mdio_mfm_pkg::mdio_req_t req,
	output logic                    res_valid,
	input  logic                    res_ready,
	output mdio_mfm_pkg::mdio_res_t res,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [7:0]              cfg_data
);
	import mdio_mfm_pkg::*;

	localparam int BW = $clog2(PREAMBLE_BITS + 34);
	localparam logic [BW-1:0] PRE_LEN  = BW'(PREAMBLE_BITS);
	localparam logic [BW-1:0] FRAME_RD = BW'(PREAMBLE_BITS + 32);
	localparam logic [BW-1:0] FRAME_WR = BW'(PREAMBLE_BITS + 33);

	logic [4:0]    phy_address_q;
	logic [7:0]    phase_ticks_q;
	mdio_op_t      kind_q, kind_n;
	logic [BW-1:0] bit_q, bit_n;
	logic [1:0]    phase_q, phase_n;
	logic [7:0]    tick_q, tick_n;
	logic [31:0]   frame_q, frame_n;
	logic [15:0]   shift_q, shift_n;
	logic          res_valid_q;
	mdio_res_t     res_q, res_n;

	logic          accept;
	logic [7:0]    limit;
	logic [7:0]    tick_inc;
	logic [BW-1:0] k_cur, k_n;
	logic [15:0]   hdr;
	logic          drv, lvl;

	assign req_ready = !res_valid_q || res_ready;
	assign accept    = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		kind_n   = kind_q;
		bit_n    = bit_q;
		phase_n  = phase_q;
		tick_n   = tick_q;
		frame_n  = frame_q;
		shift_n  = shift_q;
		res_n    = '0;
		limit    = (phase_ticks_q == 8'd0) ? 8'd1 : phase_ticks_q;
		tick_inc = tick_q + 8'd1;
		k_cur    = bit_q - PRE_LEN;
		hdr      = '0;
		case (mdio_op_t'(req.operation))
			OP_READ, OP_WRITE: begin
				if (kind_q != OP_TICK) begin
					res_n.rejected = 1'b1;
				end else begin
					hdr = {MDIO_ST,
						(req.operation == OP_READ) ? MDIO_OP_RD : MDIO_OP_WR,
						phy_address_q, req.reg_num,
						(req.operation == OP_WRITE) ? MDIO_TA_WR : MDIO_TA_RD};
					kind_n  = mdio_op_t'(req.operation);
					frame_n = {hdr,
						(req.operation == OP_WRITE) ? req.write_data : 16'd0};
					shift_n = '0;
					bit_n   = '0;
					phase_n = '0;
					tick_n  = '0;
				end
			end
			OP_TICK: begin
				if (kind_q != OP_TICK) begin
					tick_n = tick_inc;
					if (tick_inc >= limit) begin
						tick_n = '0;
						if (phase_q == 2'd1 && kind_q == OP_READ && bit_q >= PRE_LEN &&
						    k_cur >= BW'(15) && k_cur < BW'(31)) begin
							shift_n = {shift_q[14:0], req.mdio_in};
						end
						phase_n = phase_q + 2'd1;
						if (phase_q == 2'd3) begin
							bit_n = bit_q + BW'(1);
							if (bit_n >= ((kind_q == OP_WRITE) ? FRAME_WR : FRAME_RD)) begin
								if (kind_q == OP_READ) begin
									res_n.read_value = shift_n;
								end
								res_n.done_res = 1'b1;
								kind_n = OP_TICK;
								bit_n  = '0;
							end
						end
					end
				end
			end
			default: ;
		endcase

		k_n = bit_n - PRE_LEN;
		drv = 1'b0;
		lvl = 1'b0;
		if (bit_n < PRE_LEN) begin
			drv = 1'b1;
			lvl = 1'b1;
		end else if ((kind_n == OP_WRITE && k_n < BW'(32)) ||
		             (kind_n == OP_READ && k_n < BW'(14))) begin
			drv = 1'b1;
			lvl = frame_n[5'(5'd31 - k_n[4:0])];
		end
		if (kind_n != OP_TICK) begin
			res_n.mdc        = (phase_n == 2'd1) || (phase_n == 2'd2);
			res_n.mdio_out   = lvl;
			res_n.mdio_drive = drv;
			res_n.busy_res   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phy_address_q <= '0;
			phase_ticks_q <= 8'd2;
			kind_q        <= OP_TICK;
			bit_q         <= '0;
			phase_q       <= '0;
			tick_q        <= '0;
			frame_q       <= '0;
			shift_q       <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (mdio_cfg_idx_t'(cfg_index))
					CFG_PHY_ADDRESS: phy_address_q <= cfg_data[4:0];
					CFG_PHASE_TICKS: phase_ticks_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				kind_q      <= kind_n;
				bit_q       <= bit_n;
				phase_q     <= phase_n;
				tick_q      <= tick_n;
				frame_q     <= frame_n;
				shift_q     <= shift_n;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_n;
		end
	end

	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.busy_res |-> !res_q.mdc && !res_q.mdio_drive && !res_q.mdio_out)
		else $error("idle result shows active pins");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.rejected |-> res_q.busy_res && !res_q.done_res)
		else $error("rejected start without a running frame");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done_res |-> !res_q.busy_res && kind_q == OP_TICK)
		else $error("frame end left block busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind_q == OP_TICK &&
		(req.operation == OP_READ || req.operation == OP_WRITE)
		|=> kind_q != OP_TICK && res_q.busy_res && res_q.mdio_drive)
		else $error("accepted start did not open a frame");

	a_read_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.read_value != 16'd0 |-> res_q.done_res)
		else $error("read value outside a done result");

endmodule

// ----- bench/mdio_frame_checker.sv -----
`timescale 1ns / 1ps
// Checker for the MDIO clause 22 frame master: watches the request, result and
// register channels, predicts the full result of every request and compares them.
// Depends on mdio_mfm_pkg for the request and result types and codes.
module mdio_frame_checker #(
	parameter int PREAMBLE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  logic                    req_ready,
	input  mdio_mfm_pkg::mdio_req_t req,
	input  logic                    res_valid,
	input  logic                    res_ready,
	input  mdio_mfm_pkg::mdio_res_t res,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [7:0]              cfg_data,
	output int                      fail_count,
	output int                      results_due,
	output logic                    frame_live
);
	import mdio_mfm_pkg::*;

	logic [4:0]  phy_addr;
	logic [7:0]  phase_ticks;
	logic        live;
	mdio_op_t    kind;
	logic [6:0]  bit_idx;
	logic [1:0]  phase;
	logic [7:0]  tick;
	logic [31:0] frame;
	logic [15:0] read_shift;
	mdio_res_t   due_levels[$];
	mdio_res_t   want;

	task automatic report_mismatch(input string field, input logic [15:0] got,
		input logic [15:0] exp_val);
		fail_count++;
		if (fail_count <= 100) begin
			$display("%0t: %s got %h, want %h", $time, field, got, exp_val);
		end
	endtask

	function automatic mdio_res_t step_frame_master(input mdio_req_t r);
		mdio_res_t o;
		mdio_op_t  op;
		int        limit;
		int        k;
		logic [15:0] hdr;
		op = mdio_op_t'(r.operation);
		o = '0;
		if (op == OP_READ || op == OP_WRITE) begin
			if (live) begin
				o.rejected = 1'b1;
			end else begin
				hdr = {MDIO_ST, (op == OP_READ) ? MDIO_OP_RD : MDIO_OP_WR, phy_addr,
					r.reg_num, (op == OP_READ) ? MDIO_TA_RD : MDIO_TA_WR};
				live = 1'b1;
				kind = op;
				frame = {hdr, (op == OP_WRITE) ? r.write_data : 16'h0000};
				read_shift = '0;
				bit_idx = '0;
				phase = '0;
				tick = '0;
			end
		end else if (op == OP_TICK && live) begin
			limit = (phase_ticks == 8'd0) ? 1 : int'(phase_ticks);
			tick = tick + 8'd1;
			if (int'(tick) >= limit) begin
				tick = '0;
				k = int'(bit_idx) - PREAMBLE_BITS;
				if (phase == 2'd1 && kind == OP_READ && k >= 15 && k < 31) begin
					read_shift = {read_shift[14:0], r.mdio_in};
				end
				if (phase == 2'd3) begin
					phase = '0;
					bit_idx = bit_idx + 7'd1;
					if (int'(bit_idx) >= PREAMBLE_BITS + ((kind == OP_WRITE) ? 33 : 32)) begin
						if (kind == OP_READ) begin
							o.read_value = read_shift;
						end
						o.done_res = 1'b1;
						live = 1'b0;
						bit_idx = '0;
					end
				end else begin
					phase = phase + 2'd1;
				end
			end
		end
		if (live) begin
			k = int'(bit_idx) - PREAMBLE_BITS;
			if (k < 0) begin
				o.mdio_drive = 1'b1;
				o.mdio_out = 1'b1;
			end else if ((kind == OP_WRITE && k < 32) || (kind == OP_READ && k < 14)) begin
				o.mdio_drive = 1'b1;
				o.mdio_out = frame[31 - k];
			end
			o.mdc = (phase == 2'd1 || phase == 2'd2);
		end
		o.busy_res = live;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phy_addr = '0;
			phase_ticks = 8'd2;
			live = 1'b0;
			kind = OP_TICK;
			bit_idx = '0;
			phase = '0;
			tick = '0;
			frame = '0;
			read_shift = '0;
			due_levels.delete();
			fail_count = 0;
			results_due = 0;
			frame_live = 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (due_levels.size() == 0) begin
					report_mismatch("result with none due", 16'h0, 16'h0);
				end else begin
					want = due_levels.pop_front();
					if (res.mdc !== want.mdc)
						report_mismatch("mdc", 16'(res.mdc), 16'(want.mdc));
					if (res.mdio_out !== want.mdio_out)
						report_mismatch("mdio_out", 16'(res.mdio_out), 16'(want.mdio_out));
					if (res.mdio_drive !== want.mdio_drive)
						report_mismatch("mdio_drive", 16'(res.mdio_drive),
							16'(want.mdio_drive));
					if (res.busy_res !== want.busy_res)
						report_mismatch("busy_res", 16'(res.busy_res), 16'(want.busy_res));
					if (res.done_res !== want.done_res)
						report_mismatch("done_res", 16'(res.done_res), 16'(want.done_res));
					if (res.read_value !== want.read_value)
						report_mismatch("read_value", res.read_value, want.read_value);
					if (res.rejected !== want.rejected)
						report_mismatch("rejected", 16'(res.rejected), 16'(want.rejected));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (mdio_cfg_idx_t'(cfg_index))
					CFG_PHY_ADDRESS: phy_addr = cfg_data[4:0];
					CFG_PHASE_TICKS: phase_ticks = cfg_data;
					default: ;
				endcase
			end
			if (req_valid && req_ready) begin
				due_levels.push_back(step_frame_master(req));
			end
			results_due = due_levels.size();
			frame_live = live;
		end
	end

endmodule

// ----- bench/mdio_management_frame_master_tb.sv -----
`timescale 1ns / 1ps
// Top of the MDIO frame master bench: clock, reset, request and register stimulus
// over several pacing phases, and the verdict. Depends on mdio_mfm_pkg, the block
// and mdio_frame_checker, which does all prediction and comparison.
module mdio_management_frame_master_tb;
	import mdio_mfm_pkg::*;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	mdio_req_t     req;
	logic          res_valid;
	logic          res_ready;
	mdio_res_t     res;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [1:0]    cfg_index;
	logic [7:0]    cfg_data;
	int            fail_total;
	int            results_due;
	logic          frame_live;
	int            snd_idle_pct;
	int            rcv_stall_pct;

	mdio_management_frame_master DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mdio_frame_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_total),
		.results_due (results_due),
		.frame_live  (frame_live)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ready = ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic mdio_req_t make_req(input mdio_op_t op, input logic [4:0] reg_num,
		input logic [15:0] wdata, input logic mdi);
		mdio_req_t r;
		r.operation = op;
		r.reg_num = reg_num;
		r.write_data = wdata;
		r.mdio_in = mdi;
		return r;
	endfunction

	task automatic send_request(input mdio_req_t r);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req = r;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	task automatic write_register(input mdio_cfg_idx_t idx, input logic [7:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic settle_requests();
		req_valid = 1'b0;
		while (results_due != 0) @(negedge clk);
	endtask

	task automatic drain_frames();
		while (frame_live) begin
			send_request(make_req(OP_TICK, 5'($urandom_range(31)),
				16'($urandom_range(65535)), 1'($urandom_range(1))));
		end
		req_valid = 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_traffic(input int count, input bit hold_midway);
		int        sent;
		int        pick;
		bit        held;
		bit        counted;
		mdio_req_t r;
		sent = 0;
		held = 1'b0;
		while (sent < count) begin
			if (hold_midway && !held && sent >= count / 2) begin
				held = 1'b1;
				req_valid = 1'b0;
				while (results_due != 0) @(negedge clk);
			end
			pick = $urandom_range(99);
			r = make_req(OP_TICK, 5'($urandom_range(31)), 16'($urandom_range(65535)),
				1'($urandom_range(1)));
			if (pick < 4) begin
				r.operation = OP_NONE;
			end else if (pick < 10) begin
				r.operation = $urandom_range(1) ? OP_READ : OP_WRITE;
			end else if (!frame_live) begin
				if (pick >= 15)
					r.operation = $urandom_range(1) ? OP_READ : OP_WRITE;
			end
			counted = !(r.operation == OP_TICK && !frame_live);
			send_request(r);
			if (counted)
				sent++;
		end
	endtask

	initial begin
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PHY_ADDRESS;
		cfg_data = '0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: idle tick, no-op, start while busy, field extremes
		send_request(make_req(OP_TICK, 5'd0, 16'h0000, 1'b1));
		send_request(make_req(OP_NONE, 5'd31, 16'hffff, 1'b0));
		send_request(make_req(OP_READ, 5'd31, 16'hffff, 1'b1));
		send_request(make_req(OP_WRITE, 5'd0, 16'h0000, 1'b0));
		send_request(make_req(OP_NONE, 5'd0, 16'h0000, 1'b1));
		repeat (6) send_request(make_req(OP_TICK, 5'd31, 16'hffff, 1'b1));
		settle_requests();
		write_register(CFG_PHASE_TICKS, 8'd1);
		drain_frames();
		send_request(make_req(OP_WRITE, 5'd31, 16'hffff, 1'b1));
		send_request(make_req(OP_READ, 5'd0, 16'h0000, 1'b0));
		drain_frames();

		write_register(CFG_PHY_ADDRESS, 8'd31);
		write_register(CFG_PHASE_TICKS, 8'd1);
		run_traffic(120, 1'b0);

		settle_requests();
		write_register(CFG_PHY_ADDRESS, 8'($urandom_range(31)));
		snd_idle_pct = 67;
		run_traffic(100, 1'b1);

		settle_requests();
		write_register(CFG_PHY_ADDRESS, 8'($urandom_range(31)));
		write_register(CFG_PHASE_TICKS, 8'd3);
		snd_idle_pct = 0;
		rcv_stall_pct = 67;
		run_traffic(100, 1'b0);

		// zero ticks per phase behaves as one
		settle_requests();
		write_register(CFG_PHY_ADDRESS, 8'($urandom_range(31)));
		write_register(CFG_PHASE_TICKS, 8'd0);
		snd_idle_pct = 36;
		rcv_stall_pct = 36;
		run_traffic(100, 1'b0);

		settle_requests();
		write_register(CFG_PHY_ADDRESS, 8'd10);
		write_register(CFG_PHASE_TICKS, 8'd255);
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		run_traffic(20, 1'b0);

		settle_requests();
		write_register(CFG_SPARE3, 8'hff);
		write_register(CFG_PHY_ADDRESS, 8'($urandom_range(31)));
		write_register(CFG_PHASE_TICKS, 8'd2);
		snd_idle_pct = 36;
		rcv_stall_pct = 36;
		run_traffic(100, 1'b0);
		drain_frames();

		repeat (10) @(posedge clk);
		if (fail_total == 0 && results_due == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
